[src/gbm_path_price_engine_core_assert.svh]
// Assertion macros shared by the path price engine RTL
`ifndef GBM_PATH_PRICE_ENGINE_CORE_ASSERT_SVH
`define GBM_PATH_PRICE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define GPPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define GPPE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/gppe_pkg.sv]
// Package: constants, register codes and small tables of the path price engine
`default_nettype none
package gppe_pkg;

   // Register reset values
   localparam logic [31:0] START_RST  = 32'd6553600;
   localparam logic [31:0] STRIKE_RST = 32'd6881280;
   localparam logic [31:0] DRIFT_RST  = 32'd127826;
   localparam logic [31:0] VOL_RST    = 32'd13527800;
   localparam logic [10:0] STEPS_RST  = 11'd252;
   localparam logic [31:0] SEED_RST   = 32'd12346;

   // Longest path in steps
   localparam logic [10:0] STEP_MAX = 11'd1024;

   // Fixed-point constants
   localparam logic [30:0] TWO_LN2_Q30   = 31'd1488522236;
   localparam logic [30:0] ANGLE_SCALE   = 31'd1686629713;
   localparam logic [33:0] CORDIC_GAIN   = 34'd652032874;
   localparam logic [29:0] INV_LN2_Q30   = 30'd475340181;
   localparam logic [29:0] LN2_Q30       = 30'd744261118;
   localparam logic [35:0] EXP_LIMIT     = 36'd17179869184;
   localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
   localparam logic [4:0]  SQUARE_LAST   = 5'd27;
   localparam logic [4:0]  SQRT_LAST     = 5'd31;
   localparam logic [4:0]  CORDIC_LAST   = 5'd29;
   localparam logic [3:0]  TAYLOR_LAST   = 4'd13;

   // Register indexes on the configuration port
   typedef enum logic [2:0] {
      REG_START  = 3'd0,
      REG_STRIKE = 3'd1,
      REG_DRIFT  = 3'd2,
      REG_VOL    = 3'd3,
      REG_STEPS  = 3'd4,
      REG_SEED   = 3'd5
   } reg_index_type;

   // One xorshift32 advance (13, 17, 5)
   function automatic logic [31:0] xorshift32(input logic [31:0] s);
      logic [31:0] x;
      x = s ^ (s << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      return x;
   endfunction

   // Arctangent of 2^-i in Q0.30
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         5'd24: v = 30'd64;
         5'd25: v = 30'd32;
         5'd26: v = 30'd16;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // ceil(2^34 / n): exact floor division of a 30-bit value by n after >> 34
   function automatic logic [34:0] recip34(input logic [3:0] n);
      logic [34:0] v;
      case (n)
         4'd1:  v = 35'd17179869184;
         4'd2:  v = 35'd8589934592;
         4'd3:  v = 35'd5726623062;
         4'd4:  v = 35'd4294967296;
         4'd5:  v = 35'd3435973837;
         4'd6:  v = 35'd2863311531;
         4'd7:  v = 35'd2454267027;
         4'd8:  v = 35'd2147483648;
         4'd9:  v = 35'd1908874354;
         4'd10: v = 35'd1717986919;
         4'd11: v = 35'd1561806290;
         4'd12: v = 35'd1431655766;
         4'd13: v = 35'd1321528399;
         default: v = 35'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[src/gbm_path_price_engine_core.sv]
// Top level: fixed-point GBM path simulator with European call payoff
//
// Usage: configure start price, strike, drift, volatility, step count and
// seed over the csr_ port while idle; a seed write also reloads the
// generator. Each req_ transfer (clear_sum in req_tdata bit 0) runs one
// price path and gives one rsp_ transfer: final price, call payoff and the
// saturating payoff sum.
// Structure: one multiplier is shared by a sequencer. Each deviate pair
// normalises, takes log2 by repeated squaring, then a square root, CORDIC
// rotations and a few multiplies; each price step is mostly the 13-term
// exponential series. N = 0 goes straight to the result without steps.
// req_tready is high only between paths, from the cycle after the result is
// registered; one new path is taken while that result still waits.
// Reset restores register defaults, the generator word and a zero sum.
// A stalled receiver holds the result; a finished path then waits until
// the output register is free.
`default_nettype none
`include "gbm_path_price_engine_core_assert.svh"
module gbm_path_price_engine_core
   import gppe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [0] clear_sum, [7:1] zero
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,    // [31:0] final_price, [63:32] payoff,
                                      // [127:64] payoff_sum
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [26:0] {
      ST_IDLE    = 27'h0000001,
      ST_RNG_A   = 27'h0000002,
      ST_RNG_B   = 27'h0000004,
      ST_NORM    = 27'h0000008,
      ST_SQ_MUL  = 27'h0000010,
      ST_SQ_UPD  = 27'h0000020,
      ST_LOG_MUL = 27'h0000040,
      ST_SQRT_LD = 27'h0000080,
      ST_SQRT    = 27'h0000100,
      ST_ANG_MUL = 27'h0000200,
      ST_ANG_LD  = 27'h0000400,
      ST_CORDIC  = 27'h0000800,
      ST_Z1_MUL  = 27'h0001000,
      ST_Z2_MUL  = 27'h0002000,
      ST_Z2_LD   = 27'h0004000,
      ST_E_MUL   = 27'h0008000,
      ST_E_LD    = 27'h0010000,
      ST_K_MUL   = 27'h0020000,
      ST_K_LD    = 27'h0040000,
      ST_Y_MUL   = 27'h0080000,
      ST_Y_LD    = 27'h0100000,
      ST_TM_MUL  = 27'h0200000,
      ST_DV_MUL  = 27'h0400000,
      ST_DV_LD   = 27'h0800000,
      ST_P_MUL   = 27'h1000000,
      ST_P_LD    = 27'h2000000,
      ST_FINISH  = 27'h4000000
   } state_type;

   // Configuration registers
   logic [31:0] start_ff, start_in, strike_ff, strike_in;
   logic [31:0] drift_ff, drift_in, vol_ff, vol_in, seed_ff, seed_in;
   logic [10:0] steps_cfg_ff, steps_cfg_in;

   // Control and running state
   state_type state_ff, state_in;
   logic [31:0] rng_ff, rng_in;
   logic [63:0] total_ff, total_in;
   logic        clear_ff, clear_in;
   logic [31:0] price_ff, price_in;
   logic [10:0] steps_ff, steps_in, idx_ff, idx_in;
   logic        zsel_ff, zsel_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [3:0]  n_ff, n_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_data_ff, rsp_data_in;

   // Datapath registers
   logic [31:0] b_ff, b_in;
   logic [32:0] norm_ff, norm_in;
   logic [5:0]  lz_ff, lz_in;
   logic [30:0] m_ff, m_in;
   logic [27:0] f_ff, f_in;
   logic [63:0] rem_ff, rem_in, root_ff, root_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [33:0] z1_ff, z1_in, z2_ff, z2_in;
   logic signed [35:0] e_ff, e_in;
   logic signed [6:0]  k_ff, k_in;
   logic [29:0] frac_ff, frac_in, y_ff, y_in;
   logic [30:0] term_ff, term_in;
   logic [31:0] sum_ff, sum_in;
   logic signed [71:0] mul_ff, mul_in;

   // Shared multiplier operands
   logic signed [35:0] mul_a, mul_b;

   // Combinational helpers
   logic        cfg_write;
   logic [10:0] steps_eff;
   logic [31:0] word_next;
   logic [33:0] lval;
   logic [63:0] bit_val, trial;
   logic signed [33:0] dx, dy, cos_v, sin_v;
   logic signed [47:0] ew;
   logic signed [36:0] tval;
   logic signed [6:0]  shr;
   logic [63:0] pshift;
   logic [10:0] idx_next;
   logic [31:0] pay;
   logic [63:0] base;
   logic [64:0] total_sum;

   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign steps_eff = (steps_cfg_ff > STEP_MAX) ? STEP_MAX : steps_cfg_ff;
   assign word_next = xorshift32(rng_ff);
   assign lval      = {6'd1 + lz_ff, 28'd0} - {6'd0, f_ff};
   assign bit_val   = 64'd1 << (6'd62 - {cnt_ff, 1'b0});
   assign trial     = root_ff + bit_val;
   assign dx        = cy_ff >>> cnt_ff;
   assign dy        = cx_ff >>> cnt_ff;
   assign ew        = {{4{mul_ff[71]}}, mul_ff[71:28]} + {{16{drift_ff[31]}}, drift_ff};
   assign tval      = {e_ff[35], e_ff} + mul_ff[66:30];
   assign shr       = 7'sd30 - k_ff;
   assign pshift    = mul_ff[63:0] >> shr[5:0];
   assign idx_next  = idx_ff + 11'd1;
   assign pay       = (price_ff > strike_ff) ? price_ff - strike_ff : 32'd0;
   assign base      = clear_ff ? 64'd0 : total_ff;
   assign total_sum = {1'b0, base} + {33'd0, pay};

   // Rotate the CORDIC result into the quadrant of the phase
   always_comb begin
      case (b_ff[31:30])
         2'd0: begin
            cos_v = cx_ff;
            sin_v = cy_ff;
         end
         2'd1: begin
            cos_v = -cy_ff;
            sin_v = cx_ff;
         end
         2'd2: begin
            cos_v = -cx_ff;
            sin_v = -cy_ff;
         end
         default: begin
            cos_v = cy_ff;
            sin_v = -cx_ff;
         end
      endcase
   end

   // Select the operands of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ_MUL: begin
            mul_a = {5'd0, m_ff};
            mul_b = {5'd0, m_ff};
         end
         ST_LOG_MUL: begin
            mul_a = {2'd0, lval};
            mul_b = {5'd0, TWO_LN2_Q30};
         end
         ST_ANG_MUL: begin
            mul_a = {5'd0, b_ff[29:0], 1'b1};
            mul_b = {5'd0, ANGLE_SCALE};
         end
         ST_Z1_MUL: begin
            mul_a = {4'd0, root_ff[31:0]};
            mul_b = {{2{cos_v[33]}}, cos_v};
         end
         ST_Z2_MUL: begin
            mul_a = {4'd0, root_ff[31:0]};
            mul_b = {{2{sin_v[33]}}, sin_v};
         end
         ST_E_MUL: begin
            mul_a = {{4{vol_ff[31]}}, vol_ff};
            mul_b = zsel_ff ? {{2{z2_ff[33]}}, z2_ff} : {{2{z1_ff[33]}}, z1_ff};
         end
         ST_K_MUL: begin
            mul_a = e_ff;
            mul_b = {6'd0, INV_LN2_Q30};
         end
         ST_Y_MUL: begin
            mul_a = {6'd0, frac_ff};
            mul_b = {6'd0, LN2_Q30};
         end
         ST_TM_MUL: begin
            mul_a = {5'd0, term_ff};
            mul_b = {6'd0, y_ff};
         end
         ST_DV_MUL: begin
            mul_a = {5'd0, mul_ff[60:30]};
            mul_b = {1'b0, recip34(n_ff)};
         end
         ST_P_MUL: begin
            mul_a = {4'd0, price_ff};
            mul_b = {4'd0, sum_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_in = mul_a * mul_b;

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      rng_in       = rng_ff;
      total_in     = total_ff;
      clear_in     = clear_ff;
      price_in     = price_ff;
      steps_in     = steps_ff;
      idx_in       = idx_ff;
      zsel_in      = zsel_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      b_in         = b_ff;
      norm_in      = norm_ff;
      lz_in        = lz_ff;
      m_in         = m_ff;
      f_in         = f_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      z1_in        = z1_ff;
      z2_in        = z2_ff;
      e_in         = e_ff;
      k_in         = k_ff;
      frac_in      = frac_ff;
      y_in         = y_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;

      // Drop the result once the receiver takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               clear_in = req_tdata[0];
               price_in = start_ff;
               steps_in = steps_eff;
               idx_in   = '0;
               zsel_in  = 1'b0;
               state_in = (steps_eff == 11'd0) ? ST_FINISH : ST_RNG_A;
            end
         end
         ST_RNG_A: begin
            rng_in   = word_next;
            norm_in  = {word_next, 1'b1};
            lz_in    = '0;
            state_in = ST_RNG_B;
         end
         ST_RNG_B: begin
            rng_in   = word_next;
            b_in     = word_next;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            // Shift until the leading one reaches the top bit
            if (norm_ff[32]) begin
               m_in     = norm_ff[32:2];
               f_in     = '0;
               cnt_in   = '0;
               state_in = ST_SQ_MUL;
            end else begin
               norm_in = {norm_ff[31:0], 1'b0};
               lz_in   = lz_ff + 6'd1;
            end
         end
         ST_SQ_MUL: begin
            state_in = ST_SQ_UPD;
         end
         ST_SQ_UPD: begin
            // One fraction bit of log2 per squaring
            if (mul_ff[61]) begin
               m_in = mul_ff[61:31];
               f_in = {f_ff[26:0], 1'b1};
            end else begin
               m_in = mul_ff[60:30];
               f_in = {f_ff[26:0], 1'b0};
            end
            cnt_in   = cnt_ff + 5'd1;
            state_in = (cnt_ff == SQUARE_LAST) ? ST_LOG_MUL : ST_SQ_MUL;
         end
         ST_LOG_MUL: begin
            state_in = ST_SQRT_LD;
         end
         ST_SQRT_LD: begin
            rem_in   = {1'b0, mul_ff[64:30], 28'd0};
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            // One result bit per cycle
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_val;
            end else begin
               root_in = root_ff >> 1;
            end
            cnt_in   = cnt_ff + 5'd1;
            state_in = (cnt_ff == SQRT_LAST) ? ST_ANG_MUL : ST_SQRT;
         end
         ST_ANG_MUL: begin
            state_in = ST_ANG_LD;
         end
         ST_ANG_LD: begin
            cz_in    = {3'd0, mul_ff[61:31]};
            cx_in    = CORDIC_GAIN;
            cy_in    = '0;
            cnt_in   = '0;
            state_in = ST_CORDIC;
         end
         ST_CORDIC: begin
            // One rotation per cycle
            if (!cz_ff[33]) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               cz_in = cz_ff - {4'd0, atan_q30(cnt_ff)};
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               cz_in = cz_ff + {4'd0, atan_q30(cnt_ff)};
            end
            cnt_in   = cnt_ff + 5'd1;
            state_in = (cnt_ff == CORDIC_LAST) ? ST_Z1_MUL : ST_CORDIC;
         end
         ST_Z1_MUL: begin
            state_in = ST_Z2_MUL;
         end
         ST_Z2_MUL: begin
            z1_in    = mul_ff[63:30];
            state_in = ST_Z2_LD;
         end
         ST_Z2_LD: begin
            z2_in    = mul_ff[63:30];
            zsel_in  = 1'b0;
            state_in = ST_E_MUL;
         end
         ST_E_MUL: begin
            state_in = ST_E_LD;
         end
         ST_E_LD: begin
            // Clamp the exponent to +-16
            if (ew > $signed({12'd0, EXP_LIMIT})) begin
               e_in = EXP_LIMIT;
            end else if (ew < -$signed({12'd0, EXP_LIMIT})) begin
               e_in = -EXP_LIMIT;
            end else begin
               e_in = ew[35:0];
            end
            state_in = ST_K_MUL;
         end
         ST_K_MUL: begin
            state_in = ST_K_LD;
         end
         ST_K_LD: begin
            k_in     = tval[36:30];
            frac_in  = tval[29:0];
            state_in = ST_Y_MUL;
         end
         ST_Y_MUL: begin
            state_in = ST_Y_LD;
         end
         ST_Y_LD: begin
            y_in     = mul_ff[59:30];
            term_in  = ONE_Q30;
            sum_in   = {1'b0, ONE_Q30};
            n_in     = 4'd1;
            state_in = ST_TM_MUL;
         end
         ST_TM_MUL: begin
            state_in = ST_DV_MUL;
         end
         ST_DV_MUL: begin
            state_in = ST_DV_LD;
         end
         ST_DV_LD: begin
            // Accumulate one series term
            term_in  = mul_ff[64:34];
            sum_in   = sum_ff + {1'b0, mul_ff[64:34]};
            n_in     = n_ff + 4'd1;
            state_in = (n_ff == TAYLOR_LAST) ? ST_P_MUL : ST_TM_MUL;
         end
         ST_P_MUL: begin
            state_in = ST_P_LD;
         end
         ST_P_LD: begin
            // Scale by 2^k and saturate the price
            price_in = (|pshift[63:32]) ? 32'hFFFF_FFFF : pshift[31:0];
            idx_in   = idx_next;
            if (!zsel_ff && (idx_next < steps_ff)) begin
               zsel_in  = 1'b1;
               state_in = ST_E_MUL;
            end else if (idx_next < steps_ff) begin
               zsel_in  = 1'b0;
               state_in = ST_RNG_A;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               total_in     = total_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total_sum[63:0];
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(total_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : total_sum[63:0]),
                               pay, price_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A seed write reloads the generator
      if (cfg_write && (reg_index_type'(csr_paddr[4:2]) == REG_SEED)) begin
         rng_in = csr_pwdata;
      end
   end

   // Configuration register writes
   always_comb begin
      start_in     = start_ff;
      strike_in    = strike_ff;
      drift_in     = drift_ff;
      vol_in       = vol_ff;
      steps_cfg_in = steps_cfg_ff;
      seed_in      = seed_ff;
      if (cfg_write) begin
         case (reg_index_type'(csr_paddr[4:2]))
            REG_START:  start_in     = csr_pwdata;
            REG_STRIKE: strike_in    = csr_pwdata;
            REG_DRIFT:  drift_in     = csr_pwdata;
            REG_VOL:    vol_in       = csr_pwdata;
            REG_STEPS:  steps_cfg_in = csr_pwdata[10:0];
            REG_SEED:   seed_in      = csr_pwdata;
            default:    start_in     = start_ff;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      case (reg_index_type'(csr_paddr[4:2]))
         REG_START:  csr_prdata = start_ff;
         REG_STRIKE: csr_prdata = strike_ff;
         REG_DRIFT:  csr_prdata = drift_ff;
         REG_VOL:    csr_prdata = vol_ff;
         REG_STEPS:  csr_prdata = {21'd0, steps_cfg_ff};
         REG_SEED:   csr_prdata = seed_ff;
         default:    csr_prdata = 32'd0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rng_ff       <= SEED_RST;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= START_RST;
         strike_ff    <= STRIKE_RST;
         drift_ff     <= DRIFT_RST;
         vol_ff       <= VOL_RST;
         steps_cfg_ff <= STEPS_RST;
         seed_ff      <= SEED_RST;
      end else begin
         state_ff     <= state_in;
         rng_ff       <= rng_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         strike_ff    <= strike_in;
         drift_ff     <= drift_in;
         vol_ff       <= vol_in;
         steps_cfg_ff <= steps_cfg_in;
         seed_ff      <= seed_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      clear_ff    <= clear_in;
      price_ff    <= price_in;
      steps_ff    <= steps_in;
      idx_ff      <= idx_in;
      zsel_ff     <= zsel_in;
      cnt_ff      <= cnt_in;
      n_ff        <= n_in;
      rsp_data_ff <= rsp_data_in;
      b_ff        <= b_in;
      norm_ff     <= norm_in;
      lz_ff       <= lz_in;
      m_ff        <= m_in;
      f_ff        <= f_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      z1_ff       <= z1_in;
      z2_ff       <= z2_in;
      e_ff        <= e_in;
      k_ff        <= k_in;
      frac_ff     <= frac_in;
      y_ff        <= y_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      mul_ff      <= mul_in;
   end

   `GPPE_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_tvalid && req_tready, state_ff != ST_IDLE, "accepted transfer did not start a path")
   `GPPE_ASSERT_IMP(a_step_in_range, clock, reset, state_ff == ST_P_LD, idx_ff < steps_ff, "price step beyond path length")
   `GPPE_ASSERT_IMP(a_term_in_range, clock, reset, state_ff == ST_DV_LD, n_ff >= 4'd1 && n_ff <= TAYLOR_LAST, "series term index out of range")
   `GPPE_ASSERT_NXT(a_finish_emits, clock, reset, state_ff == ST_FINISH && (!rsp_valid_ff || rsp_tready), rsp_tvalid && state_ff == ST_IDLE, "finished path not presented")

endmodule
`default_nettype wire

[dv/testbench.sv]
// Testbench for the GBM path price engine: predicted paths checked against every response
`timescale 1ns / 1ps

// Predicts each path's price, payoff and running sum, and checks responses in order
class payoff_ledger;
   typedef struct {
      logic [31:0] final_price;
      logic [31:0] payoff;
      logic [63:0] payoff_sum;
   } path_result_t;

   path_result_t expected_paths[$];
   int unsigned  mismatches;
   int unsigned  paths_checked;

   // Register copies and generator state
   logic [31:0] start_price, strike_price, seed;
   longint      drift, vol;
   logic [10:0] steps_cfg;
   logic [31:0] gen_word;
   logic [63:0] sum_total;

   longint arctan_q30[30] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2};

   function new();
      start_price  = gppe_pkg::START_RST;
      strike_price = gppe_pkg::STRIKE_RST;
      drift        = longint'($signed(gppe_pkg::DRIFT_RST));
      vol          = longint'($signed(gppe_pkg::VOL_RST));
      steps_cfg    = gppe_pkg::STEPS_RST;
      seed         = gppe_pkg::SEED_RST;
      gen_word     = gppe_pkg::SEED_RST;
      sum_total    = '0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
         gppe_pkg::REG_START:  start_price = value;
         gppe_pkg::REG_STRIKE: strike_price = value;
         gppe_pkg::REG_DRIFT:  drift = longint'($signed(value));
         gppe_pkg::REG_VOL:    vol = longint'($signed(value));
         gppe_pkg::REG_STEPS:  steps_cfg = value[10:0];
         gppe_pkg::REG_SEED: begin
            seed = value;
            gen_word = value;
         end
         default: ;
      endcase
   endfunction

   function logic [31:0] draw_word();
      gen_word = gen_word ^ (gen_word << 13);
      gen_word = gen_word ^ (gen_word >> 17);
      gen_word = gen_word ^ (gen_word << 5);
      return gen_word;
   endfunction

   function logic [63:0] root64(logic [63:0] n);
      logic [63:0] res, bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // sqrt(-2 ln u1) in Q4.28
   function longint radius(logic [31:0] a);
      logic [63:0] v, m, f, lg, w;
      int p;
      v = {31'b0, a, 1'b1};
      p = 0;
      f = '0;
      while (p < 32 && (v >> (p + 1)) != 0) p++;
      m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
      for (int i = 1; i <= 28; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            f = f | (64'd1 << (28 - i));
         end
      end
      lg = (64'(33 - p) << 28) - f;
      w = (lg * 64'd1488522236) >> 30;
      return longint'(root64(w << 28));
   endfunction

   // Cosine and sine of the phase from word b, Q2.30
   function void rotate(logic [31:0] b, output longint c, output longint s);
      logic [63:0] ph, r;
      logic [1:0]  q;
      longint      x, y, z, dx, dy;
      ph = {31'b0, b, 1'b1};
      q = ph[32:31];
      r = {33'b0, ph[30:0]};
      z = longint'((r * 64'd1686629713) >> 31);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - arctan_q30[i];
         end else begin
            x = x + dx; y = y - dy; z = z + arctan_q30[i];
         end
      end
      case (q)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function void deviate_pair(output longint z1, output longint z2);
      logic [31:0] a, b;
      longint mag, c, s;
      a = draw_word();
      b = draw_word();
      mag = radius(a);
      rotate(b, c, s);
      z1 = (mag * c) >>> 30;
      z2 = (mag * s) >>> 30;
   endfunction

   // One multiplicative price update by exp(drift + vol*z)
   function logic [31:0] advance(logic [31:0] price, longint z);
      longint lim, e, t, k, f, sh;
      logic [63:0] y, term, total, p;
      lim = longint'(16) << 30;
      e = drift + ((vol * z) >>> 28);
      if (e > lim) e = lim;
      if (e < -lim) e = -lim;
      t = e + ((e * longint'(475340181)) >>> 30);
      k = t >>> 30;
      f = t - k * (longint'(1) << 30);
      y = (64'(f) * 64'd744261118) >> 30;
      term = 64'd1 << 30;
      total = 64'd1 << 30;
      for (int n = 1; n <= 13; n++) begin
         term = ((term * y) >> 30) / 64'(n);
         total = total + term;
      end
      p = {32'b0, price} * total;
      sh = k - 30;
      if (sh >= 0) begin
         if (p == 0) return 32'd0;
         if (sh >= 32) return 32'hFFFF_FFFF;
         if (p > (64'hFFFF_FFFF >> sh)) return 32'hFFFF_FFFF;
         return 32'(p << sh);
      end
      if (-sh >= 64) return 32'd0;
      p = p >> (-sh);
      return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
   endfunction

   // Note an accepted request: simulate its path and queue the response
   function void note_request(logic clear_sum);
      path_result_t exp_r;
      int unsigned  n, i;
      logic [31:0]  price, pay;
      longint       z1, z2;
      n = steps_cfg;
      if (n > gppe_pkg::STEP_MAX) n = gppe_pkg::STEP_MAX;
      i = 0;
      price = start_price;
      while (i + 1 < n) begin
         deviate_pair(z1, z2);
         price = advance(price, z1);
         price = advance(price, z2);
         i += 2;
      end
      if (i < n) begin
         deviate_pair(z1, z2);
         price = advance(price, z1);
      end
      pay = (price > strike_price) ? price - strike_price : 32'd0;
      if (clear_sum) sum_total = '0;
      if (sum_total > ~64'd0 - {32'b0, pay}) sum_total = ~64'd0;
      else sum_total = sum_total + {32'b0, pay};
      exp_r.final_price = price;
      exp_r.payoff = pay;
      exp_r.payoff_sum = sum_total;
      expected_paths.push_back(exp_r);
   endfunction

   task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
      mismatches++;
   endtask

   // Check an accepted response against the oldest expectation
   task check_result(logic [127:0] data);
      path_result_t exp_r;
      if (expected_paths.size() == 0) begin
         report_mismatch("unexpected response", data[63:0], 64'd0);
         return;
      end
      exp_r = expected_paths.pop_front();
      paths_checked++;
      if (data[31:0] !== exp_r.final_price)
         report_mismatch("final_price", data[31:0], exp_r.final_price);
      if (data[63:32] !== exp_r.payoff)
         report_mismatch("payoff", data[63:32], exp_r.payoff);
      if (data[127:64] !== exp_r.payoff_sum)
         report_mismatch("payoff_sum", data[127:64], exp_r.payoff_sum);
   endtask
endclass

module testbench;
   import gppe_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 8000000;
   localparam logic [2:0]  REG_NONE = 3'd6;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;    // [0] clear_sum, [7:1] zero
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;         // [31:0] final_price, [63:32] payoff, [127:64] payoff_sum
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   payoff_ledger ledger = new();
   int unsigned  cycles;
   int unsigned  paths_sent;
   int unsigned  settings_used;
   bit           gaps_on = 1'b1;
   bit           hold_rsp = 1'b0;

   gbm_path_price_engine_core uut (.*);

   always #1 clock = ~clock;

   // Abort on a run that never ends
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receive responses; stall at random or while held off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) ledger.check_result(rsp_tdata);
         rsp_tready <= !hold_rsp && !(gaps_on && $urandom_range(0, 99) < 14);
      end
   end

   // Hold the receiver off for a long stretch once the random part is running
   initial begin
      wait (paths_sent >= 150);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Configuration write: setup then access
   task write_reg(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      ledger.write_reg(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Offer one request and wait for its transfer
   task send_path(logic clear_sum);
      if (gaps_on && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, clear_sum};
      do @(posedge clock); while (!req_tready);
      ledger.note_request(clear_sum);
      paths_sent++;
   endtask

   task run_paths(int unsigned n);
      for (int unsigned i = 0; i < n; i++) send_path($urandom_range(0, 1));
   endtask

   // Drain so the block is idle before any register changes
   task drain();
      req_tvalid <= 1'b0;
      while (ledger.expected_paths.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      settings_used++;
   endtask

   function logic [31:0] pick_signed(logic [31:0] span);
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $urandom_range(0, span) - (span >> 1);
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults
      send_path(1'b0);
      send_path(1'b1);
      drain();
      // Short paths: zero, odd and even step counts
      for (int s = 0; s <= 3; s++) begin
         write_reg(REG_STEPS, s);
         run_paths(2);
         drain();
      end
      // Zero start price stays zero
      write_reg(REG_START, 32'd0);
      write_reg(REG_STEPS, 32'd4);
      send_path(1'b1);
      drain();
      // Price saturates high, strike at zero
      write_reg(REG_START, 32'hFFFF_FFFF);
      write_reg(REG_STRIKE, 32'd0);
      write_reg(REG_DRIFT, 32'h7FFF_FFFF);
      write_reg(REG_VOL, 32'd0);
      run_paths(2);
      drain();
      // Price collapses, strike at maximum
      write_reg(REG_STRIKE, 32'hFFFF_FFFF);
      write_reg(REG_DRIFT, 32'h8000_0000);
      send_path(1'b0);
      drain();
      // Extreme volatility both ways
      write_reg(REG_START, 32'd6553600);
      write_reg(REG_STRIKE, 32'd6553600);
      write_reg(REG_DRIFT, 32'd0);
      write_reg(REG_VOL, 32'h8000_0000);
      send_path(1'b1);
      drain();
      write_reg(REG_VOL, 32'h7FFF_FFFF);
      send_path(1'b0);
      drain();
      // Zero seed and all-ones seed
      write_reg(REG_VOL, VOL_RST);
      write_reg(REG_SEED, 32'd0);
      run_paths(2);
      drain();
      write_reg(REG_SEED, 32'hFFFF_FFFF);
      send_path(1'b0);
      drain();
      // Step count above the maximum, then the maximum itself
      write_reg(REG_STEPS, 32'h7FF);
      send_path(1'b1);
      drain();
      write_reg(REG_STEPS, 32'd1024);
      send_path(1'b0);
      drain();
      // Write to an unknown register is ignored
      write_reg(REG_NONE, 32'd3);
      send_path(1'b0);
      drain();

      // Random: short paths under changing settings
      for (int ph = 0; ph < 50; ph++) begin
         gaps_on = !(ph >= 12 && ph < 18);
         write_reg(REG_START, ($urandom_range(0, 9) == 0) ? $urandom
                                                         : $urandom_range(1, 400) << 16);
         write_reg(REG_STRIKE, ($urandom_range(0, 9) == 0) ? $urandom
                               : ledger.start_price + $urandom_range(0, 20 << 16)
                                 - (10 << 16));
         write_reg(REG_DRIFT, pick_signed(32'd400000));
         write_reg(REG_VOL, pick_signed(32'd80000000));
         write_reg(REG_STEPS, ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40)
                                                          : $urandom_range(0, 4));
         if ($urandom_range(0, 2) == 0) write_reg(REG_SEED, $urandom);
         run_paths(40);
         drain();
      end

      repeat (200) @(posedge clock);
      $display("Covered %0d paths over %0d register settings, including empty, odd,",
               paths_sent, settings_used);
      $display("saturating and maximum-length paths, zero seed and a long response stall.");
      if (ledger.mismatches == 0 && ledger.expected_paths.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
